// ----- hdl/rau_pkg.sv -----
package rau_pkg;

   localparam int unsigned OPERAND_WIDTH = 16;
   localparam int unsigned NUM_WIDTH = 33;
   localparam int unsigned DEN_WIDTH = 32;

   localparam logic [2:0] FUNC_ADD     = 3'd0;
   localparam logic [2:0] FUNC_SUB     = 3'd1;
   localparam logic [2:0] FUNC_ADD_INT = 3'd2;
   localparam logic [2:0] FUNC_SUB_INT = 3'd3;
   localparam logic [2:0] FUNC_REDUCE  = 3'd4;
   localparam logic [2:0] FUNC_QUOT    = 3'd5;
   localparam logic [2:0] FUNC_UNUSED6 = 3'd6;
   localparam logic [2:0] FUNC_UNUSED7 = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_GCD,
      ST_DIV_N,
      ST_DIV_D,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul1;
      logic gcd_step;
      logic div_start_n;
      logic div_start_d;
      logic div_step;
      logic fin_n;
      logic fin_d;
      logic fin_simple;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] func;
      logic       gcd_done;
      logic       div_done;
   } stat_type;

   typedef struct packed {
      logic [2:0]                      func;
      logic signed [OPERAND_WIDTH-1:0] a_num;
      logic signed [OPERAND_WIDTH-1:0] a_den;
      logic signed [OPERAND_WIDTH-1:0] b_num;
      logic signed [OPERAND_WIDTH-1:0] b_den;
   } req_type;

   typedef struct packed {
      logic [NUM_WIDTH-1:0] res_num;
      logic [DEN_WIDTH-1:0] res_den;
      logic                 status;
   } rsp_type;

endpackage

// ----- hdl/rau_ctrl.sv -----
module rau_ctrl
   import rau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            unique case (stat.func)
               FUNC_REDUCE: begin
                  state_in = ST_GCD;
               end
               FUNC_QUOT: begin
                  cmd.div_start_n = 1'b1;
                  state_in = ST_DIV_N;
               end
               default: begin
                  cmd.fin_simple = 1'b1;
                  state_in       = ST_OUT;
               end
            endcase
         end
         ST_GCD: begin
            if (stat.gcd_done) begin
               cmd.div_start_n = 1'b1;
               state_in = ST_DIV_N;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV_N: begin
            if (stat.div_done) begin
               cmd.fin_n = 1'b1;
               if (stat.func == FUNC_REDUCE) begin
                  cmd.div_start_d = 1'b1;
                  state_in = ST_DIV_D;
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_DIV_D: begin
            if (stat.div_done) begin
               cmd.fin_d = 1'b1;
               state_in = ST_OUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/rau_dp.sv -----
module rau_dp
   import rau_pkg::*;
(
   input  logic     clock,
   input  req_type  req_item,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp
);

   localparam int unsigned W  = OPERAND_WIDTH;
   localparam int unsigned PW = 2 * OPERAND_WIDTH;
   localparam int unsigned CW = $clog2(OPERAND_WIDTH + 1);

   logic [2:0]          func_ff;
   logic signed [W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [PW:0]  p1_ff;
   logic signed [PW:0]  p2_ff;
   logic [W:0]          x_ff, y_ff;
   logic [CW-1:0]       gk_ff;
   logic [W:0]          g_ff;
   logic [W:0]          rem_ff, quo_ff, dvs_ff;
   logic [CW-1:0]       cnt_ff;
   logic                busy_ff;
   rsp_type             rsp_ff;

   logic [W:0]  mag_an, mag_ad;
   logic [W+1:0] trial;
   logic [W:0]  rem_shift;
   logic [W:0]  g_val;
   logic [NUM_WIDTH-1:0] q_ext;
   logic signed [PW-1:0] prod_ab, prod_ba, prod_dd;

   assign mag_an = an_ff[W-1] ? -{an_ff[W-1], an_ff} : {an_ff[W-1], an_ff};
   assign mag_ad = ad_ff[W-1] ? -{ad_ff[W-1], ad_ff} : {ad_ff[W-1], ad_ff};

   // cross products at full width
   assign prod_ab = PW'(an_ff) * PW'(bd_ff);
   assign prod_ba = PW'(ad_ff) * PW'(bn_ff);
   assign prod_dd = PW'(ad_ff) * PW'(bd_ff);

   // gcd once one side reaches zero, common twos put back
   assign g_val = (x_ff | y_ff) << gk_ff;

   // restoring division step
   assign rem_shift = {rem_ff[W-1:0], quo_ff[W]};
   assign trial     = {1'b0, rem_shift} - {1'b0, dvs_ff};
   assign q_ext     = NUM_WIDTH'(quo_ff);

   assign stat.func     = func_ff;
   assign stat.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign stat.div_done = busy_ff && (cnt_ff == '0);
   assign rsp           = rsp_ff;

   always_ff @(posedge clock) begin
      // operand capture
      if (cmd.load) begin
         func_ff <= req_item.func;
         an_ff   <= req_item.a_num;
         ad_ff   <= req_item.a_den;
         bn_ff   <= req_item.b_num;
         bd_ff   <= req_item.b_den;
         busy_ff <= 1'b0;
      end
      // first products, gcd seed
      if (cmd.mul1) begin
         if (func_ff == FUNC_ADD || func_ff == FUNC_SUB) begin
            p1_ff <= (PW+1)'(prod_ab);
         end else begin
            p1_ff <= (PW+1)'(an_ff);
         end
         p2_ff <= (PW+1)'(prod_ba);
         x_ff  <= mag_an;
         y_ff  <= mag_ad;
         gk_ff <= '0;
      end
      // binary gcd step: drop common twos, strip lone twos, subtract odds
      if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_ff  <= x_ff >> 1;
            y_ff  <= y_ff >> 1;
            gk_ff <= gk_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_ff <= x_ff - y_ff;
         end else begin
            y_ff <= y_ff - x_ff;
         end
      end
      // divider start
      if (cmd.div_start_n || cmd.div_start_d) begin
         rem_ff  <= '0;
         cnt_ff  <= CW'(W + 1);
         busy_ff <= 1'b1;
         if (func_ff == FUNC_QUOT) begin
            quo_ff <= mag_an;
            dvs_ff <= mag_ad;
         end else begin
            if (cmd.div_start_n) begin
               quo_ff <= mag_an;
               dvs_ff <= g_val;
               g_ff   <= g_val;
            end else begin
               quo_ff <= mag_ad;
               dvs_ff <= g_ff;
            end
         end
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (!trial[W+1]) begin
            rem_ff <= trial[W:0];
            quo_ff <= {quo_ff[W-1:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            quo_ff <= {quo_ff[W-1:0], 1'b0};
         end
      end
      // divider idle unless the second pass starts now
      if (cmd.fin_d || (cmd.fin_n && !cmd.div_start_d)) begin
         busy_ff <= 1'b0;
      end
      // result forming
      if (cmd.fin_simple) begin
         rsp_ff.status <= 1'b0;
         case (func_ff)
            FUNC_ADD: begin
               rsp_ff.res_num <= NUM_WIDTH'(p1_ff + p2_ff);
               rsp_ff.res_den <= DEN_WIDTH'(prod_dd);
            end
            FUNC_SUB: begin
               rsp_ff.res_num <= NUM_WIDTH'(p1_ff - p2_ff);
               rsp_ff.res_den <= DEN_WIDTH'(prod_dd);
            end
            FUNC_ADD_INT: begin
               rsp_ff.res_num <= NUM_WIDTH'(p1_ff + p2_ff);
               rsp_ff.res_den <= DEN_WIDTH'(ad_ff);
            end
            FUNC_SUB_INT: begin
               rsp_ff.res_num <= NUM_WIDTH'(p1_ff - p2_ff);
               rsp_ff.res_den <= DEN_WIDTH'(ad_ff);
            end
            default: begin
               rsp_ff.res_num <= '0;
               rsp_ff.res_den <= '0;
            end
         endcase
      end
      if (cmd.fin_n) begin
         if (func_ff == FUNC_QUOT) begin
            if (mag_ad == '0) begin
               rsp_ff.status  <= 1'b1;
               rsp_ff.res_num <= '0;
               rsp_ff.res_den <= '0;
            end else begin
               rsp_ff.status  <= 1'b0;
               rsp_ff.res_num <= (an_ff[W-1] != ad_ff[W-1]) ? -q_ext : q_ext;
               rsp_ff.res_den <= DEN_WIDTH'(1);
            end
         end else begin
            rsp_ff.status  <= (g_ff == '0);
            rsp_ff.res_num <= (g_ff == '0) ? '0 : (an_ff[W-1] ? -q_ext : q_ext);
         end
      end
      if (cmd.fin_d) begin
         if (g_ff == '0) begin
            rsp_ff.res_den <= '0;
         end else begin
            rsp_ff.res_den <= ad_ff[W-1] ? -DEN_WIDTH'(quo_ff) : DEN_WIDTH'(quo_ff);
         end
      end
   end

endmodule

// ----- hdl/rational_arith_unit_top.sv -----
// channel  | ports                 | payload
// request  | req_valid / req_stall | req_item  (func, a_num, a_den, b_num, b_den)
// response | rsp_valid / rsp_stall | rsp_item  (res_num, res_den, status)
// one item in work at a time, W = operand width; add, subtract, integer ops skip gcd and divider
// quotient: one-bit-per-cycle restoring divider
// reduce: binary gcd (one shift or subtract per cycle), then two divider passes
// sync active-high reset idles the controller; a stalled result holds and stalls input
module rational_arith_unit_top
   import rau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic
   rau_dp u_dp (
      .clock     (clock),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp       (rsp_item)
   );

endmodule
